/* src/pfts_pkg.sv */
// Shared types and constants for the periodic frame transmit scheduler.
`timescale 1ns / 1ps
`default_nettype none
package pfts_pkg;
  localparam int JOB_SLOTS = 16;
  localparam int WAIT_CAP  = 50;
  localparam int MAX_OUT   = 16;
  localparam int MAX_DLC   = 8;
  localparam int SLOT_W    = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int CNT_W     = $clog2(JOB_SLOTS + 1);
  localparam int NOUT_W    = $clog2(MAX_OUT + 1);
  localparam int TIME_W    = 48;
  localparam int DUE_W     = 49;
  localparam int PER_W     = 32;
  localparam int WAIT_W    = 6;

  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_CANCEL   = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  localparam logic [1:0] KIND_REG_ACK  = 2'd0;
  localparam logic [1:0] KIND_CAN_ACK  = 2'd1;
  localparam logic [1:0] KIND_FRAME    = 2'd2;
  localparam logic [1:0] KIND_IDLE     = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TIME_W-1:0] now_time;
    logic [PER_W-1:0]  job_period;
    logic [15:0]       cancel_id;
    logic [28:0]       frame_ident;
    logic              frame_extended;
    logic              frame_remote;
    logic [3:0]        frame_length;
    logic [63:0]       frame_payload;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic              status;
    logic [15:0]       job_number;
    logic [28:0]       out_ident;
    logic              out_extended;
    logic              out_remote;
    logic [3:0]        out_length;
    logic [63:0]       out_payload;
    logic [WAIT_W-1:0] next_wait;
    logic              last_result;
  } out_res_t;

  typedef struct packed {
    logic [15:0]       id;
    logic [PER_W-1:0]  period;
    logic [DUE_W-1:0]  due;
    logic [28:0]       ident;
    logic              ext;
    logic              rem;
    logic [3:0]        len;
    logic [63:0]       data;
  } entry_t;
endpackage
`default_nettype wire

/* src/pfts_mem.sv */
// Job table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pfts_mem (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [pfts_pkg::SLOT_W-1:0] waddr,
  input  wire pfts_pkg::entry_t      wdata,
  input  wire logic [pfts_pkg::SLOT_W-1:0] raddr,
  output pfts_pkg::entry_t           rdata
);
  import pfts_pkg::*;

  entry_t mem [JOB_SLOTS];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

/* src/pfts_div.sv */
// Bit-serial remainder unit: dividend modulo divisor, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pfts_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [pfts_pkg::DUE_W-1:0] dividend,
  input  wire logic [pfts_pkg::PER_W-1:0] divisor,
  output logic                            done,
  output logic [pfts_pkg::PER_W-1:0]      remainder
);
  import pfts_pkg::*;

  localparam int STEP_W = $clog2(DUE_W + 1);

  logic [DUE_W-1:0]  dvd_r;
  logic [PER_W-1:0]  dsr_r;
  logic [PER_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [PER_W:0]    trial;
  logic [PER_W:0]    diff;

  always_comb begin
    trial = {rem_r, dvd_r[DUE_W-1]};
    diff  = trial - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !start && busy_r && (step_r == STEP_W'(DUE_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[DUE_W-2:0], 1'b0};
        if (trial >= {1'b0, dsr_r}) begin
          rem_r <= diff[PER_W-1:0];
        end else begin
          rem_r <= trial[PER_W-1:0];
        end
        if (step_r == STEP_W'(DUE_W - 1)) begin
          busy_r <= 1'b0;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;
endmodule
`default_nettype wire

/* src/periodic_frame_tx_scheduler.sv */
// Top level: periodic CAN transmit job table with tick-driven scheduling.
// Register: ack waits in S_FIN before output. Cancel walks slots via CSEL, CWAIT, CCHK.
// Tick: each valid job goes TSEL, TWAIT, TRD, TUPD; a due job also TDIV in the serial
// remainder unit and TEMIT; then FIN finishes; one request in flight at a time.
// Synchronous active-low reset clears job valid/armed bits, count and id
// counter; table memory contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none
module periodic_frame_tx_scheduler (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pfts_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pfts_pkg::out_res_t      out_data
);
  import pfts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CSEL, S_CWAIT, S_CCHK, S_TSEL, S_TWAIT, S_TRD,
    S_TDIV, S_TEMIT, S_TUPD, S_FIN
  } state_t;

  state_t              state_r;
  logic [JOB_SLOTS-1:0] valid_r;
  logic [JOB_SLOTS-1:0] armed_r;
  logic [SLOT_W-1:0]   age_r [JOB_SLOTS];
  logic [CNT_W-1:0]    cnt_r;
  logic [15:0]         idc_r;
  in_req_t             req_r;
  logic [CNT_W-1:0]    idx_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [DUE_W-1:0]    due_r;
  logic [WAIT_W-1:0]   wait_r;
  logic [NOUT_W-1:0]   nout_r;
  out_res_t            pend_r;
  logic                pend_v_r;
  logic                out_valid_r;
  out_res_t            out_r;

  entry_t              rdata;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  entry_t              mem_wdata;
  logic                div_start;
  logic                div_done;
  logic [PER_W-1:0]    div_rem;

  logic                accept;
  logic                out_free;
  logic                out_load;
  logic [SLOT_W-1:0]   free_slot;
  logic [SLOT_W-1:0]   rank_slot;
  logic                reg_ok;
  logic [DUE_W-1:0]    now_ext;
  logic [DUE_W-1:0]    due0;
  logic [DUE_W-1:0]    remain;
  logic [63:0]         pay_mask;
  logic [3:0]          len_c;
  out_res_t            frame_res;
  out_res_t            ack_res;
  out_res_t            fin_res;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free && ((state_r == S_FIN) || ((state_r == S_TEMIT) && pend_v_r));
  assign now_ext  = {1'b0, req_r.now_time};

  always_comb begin
    free_slot = '0;
    for (int i = JOB_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_slot = SLOT_W'(i);
    end
    rank_slot = '0;
    for (int i = JOB_SLOTS - 1; i >= 0; i--) begin
      if (valid_r[i] && ({1'b0, age_r[i]} == (SLOT_W+1)'(idx_r))) rank_slot = SLOT_W'(i);
    end
  end

  assign reg_ok = (in_data.job_period != '0) && (cnt_r != CNT_W'(JOB_SLOTS))
                  && (idc_r != 16'hFFFF);

  assign due0 = armed_r[slot_r] ? rdata.due
                                : (now_ext + {{(DUE_W-PER_W){1'b0}}, rdata.period});
  assign remain = (due_r > now_ext) ? (due_r - now_ext) : '0;

  always_comb begin
    len_c = (rdata.len > 4'(MAX_DLC)) ? 4'(MAX_DLC) : rdata.len;
    for (int j = 0; j < 8; j++) begin
      pay_mask[j*8 +: 8] = (4'(j) < len_c) ? 8'hFF : 8'h00;
    end
    frame_res              = '0;
    frame_res.result_kind  = KIND_FRAME;
    frame_res.job_number   = rdata.id;
    frame_res.out_ident    = rdata.ext ? rdata.ident : {18'd0, rdata.ident[10:0]};
    frame_res.out_extended = rdata.ext;
    frame_res.out_remote   = rdata.rem;
    frame_res.out_length   = len_c;
    frame_res.out_payload  = rdata.rem ? 64'd0 : (rdata.data & pay_mask);
  end

  always_comb begin
    ack_res = '0;
    case (in_data.req_type)
      REQ_REGISTER: begin
        ack_res.result_kind = KIND_REG_ACK;
        if (reg_ok) begin
          ack_res.job_number = idc_r + 16'd1;
        end else begin
          ack_res.status = 1'b1;
        end
      end
      REQ_CANCEL: begin
        ack_res.result_kind = KIND_CAN_ACK;
        ack_res.job_number  = in_data.cancel_id;
        ack_res.status      = (in_data.cancel_id == 16'd0);
      end
      default: ack_res = '0;
    endcase
  end

  always_comb begin
    fin_res = pend_r;
    fin_res.last_result = 1'b1;
    if (req_r.req_type == REQ_TICK) begin
      fin_res.next_wait = wait_r;
      if (!pend_v_r) fin_res.result_kind = KIND_IDLE;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = rdata;
    mem_wdata.due = due_r;
    if (state_r == S_IDLE) begin
      mem_we    = accept && (in_data.req_type == REQ_REGISTER) && reg_ok;
      mem_waddr = free_slot;
      mem_wdata.id     = idc_r + 16'd1;
      mem_wdata.period = in_data.job_period;
      mem_wdata.due    = '0;
      mem_wdata.ident  = in_data.frame_ident;
      mem_wdata.ext    = in_data.frame_extended;
      mem_wdata.rem    = in_data.frame_remote;
      mem_wdata.len    = in_data.frame_length;
      mem_wdata.data   = in_data.frame_payload;
    end else if (state_r == S_TUPD) begin
      mem_we = 1'b1;
    end
  end

  assign div_start = (state_r == S_TRD) && (now_ext >= due0)
                     && (nout_r != NOUT_W'(MAX_OUT));

  pfts_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (slot_r),
    .rdata (rdata)
  );

  pfts_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (now_ext - due0),
    .divisor   (rdata.period),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      armed_r     <= '0;
      cnt_r       <= '0;
      idc_r       <= '0;
      nout_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r  <= in_data;
            pend_r <= ack_res;
            idx_r  <= '0;
            nout_r <= '0;
            wait_r <= WAIT_W'(WAIT_CAP);
            case (in_data.req_type)
              REQ_REGISTER: begin
                pend_v_r <= 1'b1;
                state_r  <= S_FIN;
                if (reg_ok) begin
                  for (int i = 0; i < JOB_SLOTS; i++) begin
                    if (valid_r[i]) age_r[i] <= age_r[i] + 1'b1;
                  end
                  age_r[free_slot]   <= '0;
                  valid_r[free_slot] <= 1'b1;
                  armed_r[free_slot] <= 1'b0;
                  cnt_r <= cnt_r + 1'b1;
                  idc_r <= idc_r + 16'd1;
                end
              end
              REQ_CANCEL: begin
                if (in_data.cancel_id == 16'd0) begin
                  pend_v_r <= 1'b1;
                  state_r  <= S_FIN;
                end else begin
                  state_r <= S_CSEL;
                end
              end
              REQ_TICK: state_r <= S_TSEL;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_CSEL: begin
          if (idx_r == CNT_W'(JOB_SLOTS)) begin
            pend_r.status <= 1'b1;
            pend_v_r <= 1'b1;
            state_r  <= S_FIN;
          end else begin
            slot_r  <= idx_r[SLOT_W-1:0];
            state_r <= S_CWAIT;
          end
        end
        S_CWAIT: state_r <= S_CCHK;
        S_CCHK: begin
          if (valid_r[slot_r] && (rdata.id == req_r.cancel_id)) begin
            valid_r[slot_r] <= 1'b0;
            armed_r[slot_r] <= 1'b0;
            for (int i = 0; i < JOB_SLOTS; i++) begin
              if (valid_r[i] && (age_r[i] > age_r[slot_r])) age_r[i] <= age_r[i] - 1'b1;
            end
            cnt_r    <= cnt_r - 1'b1;
            pend_v_r <= 1'b1;
            state_r  <= S_FIN;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_CSEL;
          end
        end
        S_TSEL: begin
          if (idx_r == cnt_r) begin
            state_r <= S_FIN;
          end else begin
            slot_r  <= rank_slot;
            state_r <= S_TWAIT;
          end
        end
        S_TWAIT: state_r <= S_TRD;
        S_TRD: begin
          armed_r[slot_r] <= 1'b1;
          due_r <= due0;
          state_r <= div_start ? S_TDIV : S_TUPD;
        end
        S_TDIV: begin
          if (div_done) begin
            due_r <= now_ext - {{(DUE_W-PER_W){1'b0}}, div_rem}
                     + {{(DUE_W-PER_W){1'b0}}, rdata.period};
            state_r <= S_TEMIT;
          end
        end
        S_TEMIT: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_r <= pend_r;
            end
            pend_r   <= frame_res;
            pend_v_r <= 1'b1;
            nout_r   <= nout_r + 1'b1;
            state_r  <= S_TUPD;
          end
        end
        S_TUPD: begin
          if (remain < DUE_W'(wait_r)) wait_r <= remain[WAIT_W-1:0];
          idx_r   <= idx_r + 1'b1;
          state_r <= S_TSEL;
        end
        S_FIN: begin
          if (out_free) begin
            out_r    <= fin_res;
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(JOB_SLOTS)) else $error("job count overflow");
  a_nout_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nout_r <= NOUT_W'(MAX_OUT)) else $error("too many frames per tick");
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r) else $error("pending result left behind");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid && out_data.last_result))
    else $error("final result not issued");
endmodule
`default_nettype wire
